### rtl/mahd_pkg.sv
// shared types, tables and constants of the mpeg audio header decoder
`timescale 1ns / 1ps
package mahd_pkg;

  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RES    = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  localparam logic [1:0] LAYER_RES = 2'd0;
  localparam logic [1:0] LAYER_III = 2'd1;
  localparam logic [1:0] LAYER_II  = 2'd2;
  localparam logic [1:0] LAYER_I   = 2'd3;

  localparam logic [1:0] MODE_SINGLE = 2'd3;
  localparam logic [1:0] SIDX_RES    = 2'd3;

  localparam logic [10:0] SYNC_WORD = 11'h7ff;

  localparam logic [7:0] COEF_L1   = 8'd12;
  localparam logic [7:0] COEF_HALF = 8'd72;
  localparam logic [7:0] COEF_FULL = 8'd144;

  localparam logic [10:0] SPF_L1   = 11'd384;
  localparam logic [10:0] SPF_FULL = 11'd1152;
  localparam logic [10:0] SPF_HALF = 11'd576;

  // numerator, quotient and reciprocal widths
  localparam int NUM_W   = 23;
  localparam int QUO_W   = 12;
  localparam int RCP_SH  = 24;
  localparam int RCP_W   = 20;
  localparam int DIV_W   = 9;

  localparam int D_44K1 = 441;
  localparam int D_48K  = 48;
  localparam int D_32K  = 32;

  localparam logic [RCP_W-1:0] RCP_44K1 = RCP_W'((2 ** RCP_SH) / D_44K1);
  localparam logic [RCP_W-1:0] RCP_48K  = RCP_W'((2 ** RCP_SH) / D_48K);
  localparam logic [RCP_W-1:0] RCP_32K  = RCP_W'((2 ** RCP_SH) / D_32K);

  typedef enum logic [1:0] {
    DIV_44K1,
    DIV_48K,
    DIV_32K
  } div_sel_t;

  // rows: mpeg-1 l1, mpeg-1 l2, mpeg-1 l3, mpeg-2/2.5 l1, mpeg-2/2.5 l2/l3
  localparam logic [8:0] BR_TAB [0:4][0:15] = '{
    '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
    '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
    '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
    '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
  };

  // rows: rate index; columns: mpeg-1, mpeg-2, mpeg-2.5
  localparam logic [15:0] SR_TAB [0:2][0:2] = '{
    '{16'd44100, 16'd22050, 16'd11025},
    '{16'd48000, 16'd24000, 16'd12000},
    '{16'd32000, 16'd16000, 16'd8000}
  };

  typedef struct packed {
    logic        valid_res;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic        crc_protected;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic        padding;
    logic [1:0]  channel_mode;
    logic [1:0]  emphasis;
    logic [2:0]  side_flags;
    logic [10:0] frame_samples;
  } info_t;

  typedef struct packed {
    logic [7:0] coef;
    logic [1:0] shift;
    div_sel_t   div_sel;
    logic       slot4;
  } len_ctrl_t;

  function automatic logic [DIV_W-1:0] div_const(div_sel_t sel);
    logic [DIV_W-1:0] d;
    unique case (sel)
      DIV_44K1: d = DIV_W'(D_44K1);
      DIV_48K:  d = DIV_W'(D_48K);
      DIV_32K:  d = DIV_W'(D_32K);
      default:  d = DIV_W'(D_32K);
    endcase
    return d;
  endfunction

  function automatic logic [RCP_W-1:0] recip_const(div_sel_t sel);
    logic [RCP_W-1:0] m;
    unique case (sel)
      DIV_44K1: m = RCP_44K1;
      DIV_48K:  m = RCP_48K;
      DIV_32K:  m = RCP_32K;
      default:  m = RCP_32K;
    endcase
    return m;
  endfunction

endpackage

### rtl/mahd_decode.sv
// first stage: field split, table lookups and legality check
`timescale 1ns / 1ps
module mahd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        header_word,
  output logic               out_valid,
  output mahd_pkg::info_t    info,
  output mahd_pkg::len_ctrl_t ctrl
);

  logic [1:0] ver;
  logic [1:0] lay;
  logic [3:0] bidx;
  logic [1:0] sidx;
  logic [1:0] mode;
  logic       sync;
  logic       mpeg1;
  logic       mpeg2x;
  logic [2:0] br_row;
  logic [1:0] sr_col;
  logic [8:0] br;
  logic [15:0] sr;
  logic [10:0] spf;
  logic       ok;
  logic       forbid;
  mahd_pkg::info_t     info_next;
  mahd_pkg::len_ctrl_t ctrl_next;

  always_comb begin
    ver    = header_word[20:19];
    lay    = header_word[18:17];
    bidx   = header_word[15:12];
    sidx   = header_word[11:10];
    mode   = header_word[7:6];
    sync   = (header_word[31:21] == mahd_pkg::SYNC_WORD);
    mpeg1  = (ver == mahd_pkg::VER_MPEG1);
    mpeg2x = (ver == mahd_pkg::VER_MPEG25) || (ver == mahd_pkg::VER_MPEG2);

    if (mpeg1) begin
      br_row = 3'(2'd3 - lay);
    end else if (lay == mahd_pkg::LAYER_I) begin
      br_row = 3'd3;
    end else begin
      br_row = 3'd4;
    end
    br = 9'd0;
    if ((lay != mahd_pkg::LAYER_RES) && (mpeg1 || mpeg2x)) begin
      br = mahd_pkg::BR_TAB[br_row][bidx];
    end

    unique case (ver)
      mahd_pkg::VER_MPEG1:  sr_col = 2'd0;
      mahd_pkg::VER_MPEG2:  sr_col = 2'd1;
      default:              sr_col = 2'd2;
    endcase
    sr = 16'd0;
    if ((sidx != mahd_pkg::SIDX_RES) && (ver != mahd_pkg::VER_RES)) begin
      sr = mahd_pkg::SR_TAB[sidx][sr_col];
    end

    unique case (lay)
      mahd_pkg::LAYER_I:   spf = mahd_pkg::SPF_L1;
      mahd_pkg::LAYER_II:  spf = mahd_pkg::SPF_FULL;
      mahd_pkg::LAYER_III: spf = mpeg2x ? mahd_pkg::SPF_HALF : mahd_pkg::SPF_FULL;
      default:             spf = 11'd0;
    endcase

    // mpeg-1 layer ii bitrate and mode pairs
    forbid = 1'b0;
    if (br == 9'd32 || br == 9'd48 || br == 9'd56 || br == 9'd80) begin
      forbid = (mode != mahd_pkg::MODE_SINGLE);
    end else if (br == 9'd224 || br == 9'd256 || br == 9'd320 || br == 9'd384) begin
      forbid = (mode == mahd_pkg::MODE_SINGLE);
    end

    ok = (lay != mahd_pkg::LAYER_RES) && (br != 9'd0) && (sr != 16'd0)
         && !(mpeg1 && (lay == mahd_pkg::LAYER_II) && forbid);

    info_next = '0;
    if (sync) begin
      info_next.valid_res         = ok;
      info_next.version_code      = ver;
      info_next.layer_code        = lay;
      info_next.crc_protected     = ~header_word[16];
      info_next.bitrate_kbps      = br;
      info_next.sample_rate_hz    = sr;
      info_next.padding           = header_word[9];
      info_next.channel_mode      = mode;
      info_next.emphasis          = header_word[1:0];
      info_next.side_flags        = {header_word[8], header_word[3], header_word[2]};
      info_next.frame_samples     = spf;
    end

    ctrl_next.slot4 = (lay == mahd_pkg::LAYER_I);
    if (lay == mahd_pkg::LAYER_I) begin
      ctrl_next.coef = mahd_pkg::COEF_L1;
    end else if ((lay == mahd_pkg::LAYER_III) && mpeg2x) begin
      ctrl_next.coef = mahd_pkg::COEF_HALF;
    end else begin
      ctrl_next.coef = mahd_pkg::COEF_FULL;
    end
    // sample rate as base rate shifted down by version
    unique case (ver)
      mahd_pkg::VER_MPEG2:  ctrl_next.shift = 2'd1;
      mahd_pkg::VER_MPEG25: ctrl_next.shift = 2'd2;
      default:              ctrl_next.shift = 2'd0;
    endcase
    unique case (sidx)
      2'd0:    ctrl_next.div_sel = mahd_pkg::DIV_44K1;
      2'd1:    ctrl_next.div_sel = mahd_pkg::DIV_48K;
      default: ctrl_next.div_sel = mahd_pkg::DIV_32K;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    info <= info_next;
    ctrl <= ctrl_next;
  end

endmodule

### rtl/mahd_len_div.sv
// frame length quotient: numerator, reciprocal multiply and one-step correction
`timescale 1ns / 1ps
module mahd_len_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  mahd_pkg::info_t           in_info,
  input  mahd_pkg::len_ctrl_t       in_ctrl,
  output logic                      out_valid,
  output mahd_pkg::info_t           out_info,
  output mahd_pkg::len_ctrl_t       out_ctrl,
  output logic [mahd_pkg::QUO_W-1:0] quotient
);

  localparam int NW = mahd_pkg::NUM_W;
  localparam int QW = mahd_pkg::QUO_W;
  localparam int PW = NW + mahd_pkg::RCP_W;

  logic [16:0]  kb;
  logic [NW-1:0] sh;
  logic [NW-1:0] num_next;
  logic [PW-1:0] prod;
  logic [NW-1:0] back;
  logic [NW-1:0] rem;
  logic [QW-1:0] q_next;

  logic                v2, v3, v4;
  mahd_pkg::info_t     info2, info3;
  mahd_pkg::len_ctrl_t ctrl2, ctrl3;
  logic [NW-1:0]       num2, num3;
  logic [QW-1:0]       qest3;

  always_comb begin
    kb = 17'(in_ctrl.coef) * 17'(in_info.bitrate_kbps);
    sh = NW'(kb) << in_ctrl.shift;
    // 44.1 kHz family divides by 441 after scaling by ten
    if (in_ctrl.div_sel == mahd_pkg::DIV_44K1) begin
      num_next = (sh << 3) + (sh << 1);
    end else begin
      num_next = sh;
    end
  end

  always_comb begin
    prod = PW'(num2) * PW'(mahd_pkg::recip_const(ctrl2.div_sel));
  end

  always_comb begin
    back   = NW'(qest3) * NW'(mahd_pkg::div_const(ctrl3.div_sel));
    rem    = num3 - back;
    q_next = qest3;
    if (rem >= NW'(mahd_pkg::div_const(ctrl3.div_sel))) begin
      q_next = qest3 + QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v2 <= in_valid;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    num2     <= num_next;
    info2    <= in_info;
    ctrl2    <= in_ctrl;
    num3     <= num2;
    qest3    <= prod[mahd_pkg::RCP_SH +: QW];
    info3    <= info2;
    ctrl3    <= ctrl2;
    quotient <= q_next;
    out_info <= info3;
    out_ctrl <= ctrl3;
  end

  assign out_valid = v4;

endmodule

### rtl/mpeg_audio_header_decoder.sv
// top level of the mpeg audio frame header decoder
//
// one 32-bit candidate header word enters on header_word with start; a word
// is taken at every rising edge where start is high and busy is low. busy is
// never raised, so a new word can be offered in every cycle.
// each word gives exactly one result beat: done is high for one cycle with
// the decoded fields and the frame length on the result ports.
// the word passes through decode, numerator, reciprocal multiply, quotient
// correction and the length and output register, in that order, before done
// rises and the beat is taken.
// throughput: one word per cycle; the length divide by the sample rate is a
// multiply by a constant reciprocal per rate family, pipelined over three
// stages, so it never holds the input off.
// a word without sync gives all-zero fields; any illegal field clears
// valid_res and forces frame_length_bytes to zero.
// reset clears the in-flight valid bits, so no beat appears for words taken
// before it. the receiver cannot stall: every beat is taken as it shows.
`timescale 1ns / 1ps
module mpeg_audio_header_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] header_word,
  output logic        done,
  output logic        valid_res,
  output logic [1:0]  version_code,
  output logic [1:0]  layer_code,
  output logic        crc_protected,
  output logic [8:0]  bitrate_kbps,
  output logic [15:0] sample_rate_hz,
  output logic        padding,
  output logic [1:0]  channel_mode,
  output logic [1:0]  emphasis,
  output logic [2:0]  side_flags,
  output logic [11:0] frame_length_bytes,
  output logic [10:0] frame_samples
);

  logic                      s1_valid;
  mahd_pkg::info_t           s1_info;
  mahd_pkg::len_ctrl_t       s1_ctrl;
  logic                      s4_valid;
  mahd_pkg::info_t           s4_info;
  mahd_pkg::len_ctrl_t       s4_ctrl;
  logic [mahd_pkg::QUO_W-1:0] s4_quo;
  logic [11:0]               slots;
  logic [11:0]               len_next;

  assign busy = 1'b0;

  mahd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .header_word(header_word),
    .out_valid  (s1_valid),
    .info       (s1_info),
    .ctrl       (s1_ctrl)
  );

  mahd_len_div u_len_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_info  (s1_info),
    .in_ctrl  (s1_ctrl),
    .out_valid(s4_valid),
    .out_info (s4_info),
    .out_ctrl (s4_ctrl),
    .quotient (s4_quo)
  );

  always_comb begin
    slots    = 12'(s4_quo) + 12'(s4_info.padding);
    len_next = 12'd0;
    if (s4_info.valid_res) begin
      len_next = s4_ctrl.slot4 ? {slots[9:0], 2'b00} : slots;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    valid_res          <= s4_info.valid_res;
    version_code       <= s4_info.version_code;
    layer_code         <= s4_info.layer_code;
    crc_protected      <= s4_info.crc_protected;
    bitrate_kbps       <= s4_info.bitrate_kbps;
    sample_rate_hz     <= s4_info.sample_rate_hz;
    padding            <= s4_info.padding;
    channel_mode       <= s4_info.channel_mode;
    emphasis           <= s4_info.emphasis;
    side_flags         <= s4_info.side_flags;
    frame_samples      <= s4_info.frame_samples;
    frame_length_bytes <= len_next;
  end

endmodule

### rtl/mahd_checker.sv
// port-level checks of the mpeg audio header decoder and their binding
`timescale 1ns / 1ps
module mahd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] header_word,
  input logic        done,
  input logic        valid_res,
  input logic [1:0]  version_code,
  input logic [1:0]  layer_code,
  input logic        crc_protected,
  input logic [8:0]  bitrate_kbps,
  input logic [15:0] sample_rate_hz,
  input logic        padding,
  input logic [1:0]  channel_mode,
  input logic [1:0]  emphasis,
  input logic [2:0]  side_flags,
  input logic [11:0] frame_length_bytes,
  input logic [10:0] frame_samples
);

  // checks that every accepted word gives its result beat
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted header produced no result beat");

  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (frame_length_bytes == 12'd0))
    else $error("invalid header with non-zero frame length");

  a_valid_fields: assert property (@(posedge clk) disable iff (rst)
    (done && valid_res) |-> (layer_code != mahd_pkg::LAYER_RES
      && version_code != mahd_pkg::VER_RES && bitrate_kbps != 9'd0
      && sample_rate_hz != 16'd0 && frame_length_bytes != 12'd0))
    else $error("valid header with reserved or empty field");

  a_l1_slots: assert property (@(posedge clk) disable iff (rst)
    (done && layer_code == mahd_pkg::LAYER_I) |-> (frame_length_bytes[1:0] == 2'b00))
    else $error("layer i frame length not whole slots");

  a_spf: assert property (@(posedge clk) disable iff (rst)
    (done && valid_res && layer_code == mahd_pkg::LAYER_I)
      |-> (frame_samples == mahd_pkg::SPF_L1))
    else $error("layer i samples per frame wrong");

endmodule

bind mpeg_audio_header_decoder mahd_checker u_mahd_checker (.*);
